@@ design/ghsp_pkg.sv @@
// Shared types and constants for the generational handle slot pool.
package ghsp_pkg;

  localparam int unsigned CAPACITY_DEF = 256;
  localparam int unsigned GEN_BITS_DEF = 16;

  // Request codes
  localparam logic [2:0] FUNC_REGISTER = 3'd0;
  localparam logic [2:0] FUNC_RELEASE  = 3'd1;
  localparam logic [2:0] FUNC_MARK     = 3'd2;
  localparam logic [2:0] FUNC_QUERY    = 3'd3;
  localparam logic [2:0] FUNC_TOUCH    = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd1;
  localparam logic [1:0] ST_BAD_KIND  = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]  func;
    logic [2:0]  resource_kind;
    logic [8:0]  handle_index;
    logic [15:0] handle_generation;
    logic [39:0] byte_size;
    logic [31:0] frame_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  out_index;
    logic [15:0] out_generation;
    logic        is_pending;
    logic [31:0] last_frame;
    logic [8:0]  alive_total;
    logic [8:0]  free_total;
    logic [8:0]  slot_total;
    logic [8:0]  pending_total;
    logic [47:0] alive_bytes;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic lookup_done;
  } stat_t;

endpackage

@@ design/ghsp_ctrl.sv @@
// Controller state machine: capture a request, then execute it.
module ghsp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ghsp_pkg::stat_t stat_i,
  output ghsp_pkg::ctrl_t ctrl_o,
  output logic          busy_o
);
  import ghsp_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  // Advance from idle to execute on start, and back to idle when the lookup is done
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_EXEC;
      S_EXEC: if (stat_i.lookup_done) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o          = (state_q == S_EXEC);
  assign ctrl_o.capture  = start_i && (state_q == S_IDLE);
  assign ctrl_o.execute  = (state_q == S_EXEC);

  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.capture |=> ctrl_o.execute) else $error("capture not followed by execute");
  a_exec_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.execute |=> !ctrl_o.execute) else $error("execute held two cycles");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.capture && ctrl_o.execute)) else $error("capture during execute");
endmodule

@@ design/ghsp_datapath.sv @@
// Slot memories, free stack, running counters and result register.
module ghsp_datapath #(
  parameter int unsigned CAPACITY = ghsp_pkg::CAPACITY_DEF,
  parameter int unsigned GEN_BITS = ghsp_pkg::GEN_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ghsp_pkg::ctrl_t ctrl_i,
  input  ghsp_pkg::req_t  req_i,
  output ghsp_pkg::stat_t stat_o,
  output logic            done_o,
  output ghsp_pkg::rsp_t  rsp_o
);
  import ghsp_pkg::*;

  localparam int unsigned SW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [47:0] BYTES_MAX = '1;

  // Slot memories, one port each
  logic [GEN_BITS-1:0] gen_mem       [CAPACITY];
  logic [2:0]          kind_mem      [CAPACITY];
  logic                pend_mem      [CAPACITY];
  logic [39:0]         bytes_mem     [CAPACITY];
  logic [31:0]         frame_mem     [CAPACITY];
  logic [SW-1:0]       stack_mem     [CAPACITY];
  // Generation of each freed slot, kept beside its stack entry
  logic [GEN_BITS-1:0] stack_gen_mem [CAPACITY];
  logic [CAPACITY-1:0] alive_q;
  // Set once a slot's generation has been written; until then it reads as one
  logic [CAPACITY-1:0] gen_valid_q;

  req_t          req_q;
  logic [SW-1:0] slot_q;
  logic [CW-1:0] free_depth_q, high_water_q, alive_cnt_q, pend_cnt_q;
  logic [49:0]   bytes_sum_q;
  rsp_t          rsp_q;
  logic          done_q;

  logic [GEN_BITS-1:0] gen_rd_q;
  logic [2:0]          kind_rd_q;
  logic                pend_rd_q;
  logic [39:0]         bytes_rd_q;
  logic [31:0]         frame_rd_q;
  logic [SW-1:0]       stack_rd_q;
  logic [GEN_BITS-1:0] stack_gen_rd_q;

  // Pick the slot address for the lookup
  logic [SW-1:0] addr;
  logic [CW-1:0] idx_m1;
  assign idx_m1 = CW'({1'b0, req_i.handle_index} - 10'd1);
  assign addr   = idx_m1[SW-1:0];

  logic [CW-1:0] top;
  assign top = free_depth_q - CW'(1);

  // Capture request and read memories
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      req_q          <= req_i;
      gen_rd_q       <= gen_mem[addr];
      kind_rd_q      <= kind_mem[addr];
      pend_rd_q      <= pend_mem[addr];
      bytes_rd_q     <= bytes_mem[addr];
      frame_rd_q     <= frame_mem[addr];
      stack_rd_q     <= stack_mem[top[SW-1:0]];
      stack_gen_rd_q <= stack_gen_mem[top[SW-1:0]];
      slot_q         <= addr;
    end
  end

  // Decode the captured request
  logic [GEN_BITS-1:0] gen_cur, gen_next;
  logic                idx_ok, hit, is_reg, reg_ok;
  logic [SW-1:0]       new_slot;
  logic [1:0]          status;
  logic [CW-1:0]       hidx;
  assign hidx    = CW'(req_q.handle_index);
  assign gen_cur = gen_valid_q[slot_q] ? gen_rd_q : GEN_BITS'(1);
  assign gen_next = (gen_cur + GEN_BITS'(1) == '0) ? GEN_BITS'(1) : gen_cur + GEN_BITS'(1);
  assign idx_ok  = (req_q.handle_index != 9'd0) && ({1'b0, req_q.handle_index} <= 10'(high_water_q))
                   && (hidx <= CAP_C);
  assign hit     = idx_ok && alive_q[slot_q] &&
                   (gen_cur == GEN_BITS'(req_q.handle_generation)) &&
                   (kind_rd_q == req_q.resource_kind);
  assign is_reg  = (req_q.func == FUNC_REGISTER);
  assign new_slot = (free_depth_q != '0) ? stack_rd_q : high_water_q[SW-1:0];
  assign reg_ok  = is_reg && (req_q.resource_kind != 3'd0) &&
                   !((free_depth_q == '0) && (high_water_q >= CAP_C));

  always_comb begin
    status = ST_OK;
    if (is_reg) begin
      if (req_q.resource_kind == 3'd0) status = ST_BAD_KIND;
      else if (!reg_ok) status = ST_FULL;
    end else if (req_q.func <= FUNC_TOUCH && !hit) begin
      status = ST_BAD_HANDLE;
    end
  end

  logic op_rel, op_mark, op_touch, op_look;
  assign op_rel   = hit && (req_q.func == FUNC_RELEASE);
  assign op_mark  = hit && (req_q.func == FUNC_MARK);
  assign op_touch = hit && (req_q.func == FUNC_TOUCH);
  assign op_look  = hit && (req_q.func == FUNC_MARK || req_q.func == FUNC_QUERY ||
                            req_q.func == FUNC_TOUCH);

  // Write memories on execute
  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      if (reg_ok) begin
        kind_mem[new_slot]  <= req_q.resource_kind;
        pend_mem[new_slot]  <= 1'b0;
        bytes_mem[new_slot] <= req_q.byte_size;
        frame_mem[new_slot] <= '0;
      end else if (op_rel) begin
        gen_mem[slot_q]  <= gen_next;
        pend_mem[slot_q] <= 1'b0;
        if (free_depth_q < CAP_C) begin
          stack_mem[free_depth_q[SW-1:0]]     <= slot_q;
          stack_gen_mem[free_depth_q[SW-1:0]] <= gen_next;
        end
      end else if (op_mark) begin
        pend_mem[slot_q] <= 1'b1;
      end else if (op_touch) begin
        frame_mem[slot_q] <= req_q.frame_index;
      end
    end
  end

  // Register generation: a reused slot carries it on the stack, a fresh slot starts at one
  logic [GEN_BITS-1:0] reg_gen;
  assign reg_gen = (free_depth_q != '0) ? stack_gen_rd_q : GEN_BITS'(1);

  // Advance counters and form the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q      <= '0;
      gen_valid_q  <= '0;
      free_depth_q <= '0;
      high_water_q <= '0;
      alive_cnt_q  <= '0;
      pend_cnt_q   <= '0;
      bytes_sum_q  <= '0;
      done_q       <= 1'b0;
    end else begin
      done_q <= ctrl_i.execute;
      if (ctrl_i.execute) begin
        if (reg_ok) begin
          alive_q[new_slot] <= 1'b1;
          alive_cnt_q <= alive_cnt_q + CW'(1);
          bytes_sum_q <= bytes_sum_q + 50'(req_q.byte_size);
          if (free_depth_q != '0) free_depth_q <= free_depth_q - CW'(1);
          else high_water_q <= high_water_q + CW'(1);
        end else if (op_rel) begin
          alive_q[slot_q] <= 1'b0;
          gen_valid_q[slot_q] <= 1'b1;
          alive_cnt_q <= alive_cnt_q - CW'(1);
          if (pend_rd_q) pend_cnt_q <= pend_cnt_q - CW'(1);
          bytes_sum_q <= bytes_sum_q - 50'(bytes_rd_q);
          if (free_depth_q < CAP_C) free_depth_q <= free_depth_q + CW'(1);
        end else if (op_mark && !pend_rd_q) begin
          pend_cnt_q <= pend_cnt_q + CW'(1);
        end
      end
    end
  end

  // Count values after this request
  logic [CW-1:0] alive_n, free_n, hw_n, pend_n;
  logic [49:0]   sum_n;
  always_comb begin
    alive_n = alive_cnt_q; free_n = free_depth_q; hw_n = high_water_q;
    pend_n = pend_cnt_q; sum_n = bytes_sum_q;
    if (reg_ok) begin
      alive_n = alive_cnt_q + CW'(1);
      sum_n   = bytes_sum_q + 50'(req_q.byte_size);
      if (free_depth_q != '0) free_n = free_depth_q - CW'(1);
      else hw_n = high_water_q + CW'(1);
    end else if (op_rel) begin
      alive_n = alive_cnt_q - CW'(1);
      if (pend_rd_q) pend_n = pend_cnt_q - CW'(1);
      sum_n = bytes_sum_q - 50'(bytes_rd_q);
      if (free_depth_q < CAP_C) free_n = free_depth_q + CW'(1);
    end else if (op_mark && !pend_rd_q) begin
      pend_n = pend_cnt_q + CW'(1);
    end
  end

  // Hold the result word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      rsp_q.status         <= status;
      rsp_q.out_index      <= reg_ok ? 9'({1'b0, new_slot} + (SW+1)'(1)) : 9'd0;
      rsp_q.out_generation <= reg_ok ? 16'(reg_gen) : (op_look ? 16'(gen_cur) : 16'd0);
      rsp_q.is_pending     <= op_look ? (op_mark | pend_rd_q) : 1'b0;
      rsp_q.last_frame     <= op_touch ? req_q.frame_index : (op_look ? frame_rd_q : 32'd0);
      rsp_q.alive_total    <= 9'(alive_n);
      rsp_q.free_total     <= 9'(free_n);
      rsp_q.slot_total     <= 9'(hw_n);
      rsp_q.pending_total  <= 9'(pend_n);
      rsp_q.alive_bytes    <= (sum_n > 50'(BYTES_MAX)) ? BYTES_MAX : sum_n[47:0];
    end
  end

  assign stat_o.lookup_done = ctrl_i.execute;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.execute |=> done_o) else $error("result not delivered");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alive_cnt_q <= high_water_q) else $error("live count above high water");
  a_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q <= alive_cnt_q) else $error("pending count above live count");
endmodule

@@ design/generational_handle_slot_pool.sv @@
// Top level of the generational handle slot pool.
// Each request is handled in turn: start with busy low captures the word and reads the
// slot memories, the next cycle writes them back and registers the result, which is
// shown on rsp_o with done_o high for one cycle after that. busy is high during the
// execute cycle, so a new request can be started only while busy is low; the single-port
// read-then-write of the slot memories makes this so. The receiver cannot stall.
// No clearing pass is needed after reset.
module generational_handle_slot_pool #(
  parameter int unsigned CAPACITY = ghsp_pkg::CAPACITY_DEF,
  parameter int unsigned GEN_BITS = ghsp_pkg::GEN_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  ghsp_pkg::req_t req_i,
  output logic           done_o,
  output ghsp_pkg::rsp_t rsp_o
);
  import ghsp_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Sequence each request
  ghsp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .ctrl_o (ctrl),
    .busy_o (busy)
  );

  // Hold the pool state
  ghsp_datapath #(.CAPACITY(CAPACITY), .GEN_BITS(GEN_BITS)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(ctrl),
    .req_i (req_i),
    .stat_o(stat),
    .done_o(done_o),
    .rsp_o (rsp_o)
  );
endmodule

@@ tb/sv/tb.sv @@
// Testbench for the generational handle slot pool: directed and random requests.
`timescale 1ns / 100ps

module tb;
  import ghsp_pkg::*;

  localparam int unsigned CAP = 256;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  req_t   req_i = '0;
  logic   done_o;
  rsp_t   rsp_o;

  generational_handle_slot_pool u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the pool
  logic        pool_alive [CAP];
  logic [15:0] pool_gen   [CAP];
  logic [2:0]  pool_kind  [CAP];
  logic        pool_pend  [CAP];
  logic [39:0] pool_bytes [CAP];
  logic [31:0] pool_frame [CAP];
  int unsigned free_list  [CAP];
  int unsigned free_depth, high_water, live_count, pend_count;
  longint unsigned byte_sum;

  // Expected words in flight, written and read through separate pointers
  rsp_t        expected_rsp [4];
  int unsigned exp_wr, exp_rd;
  int unsigned errors, words_sent, words_checked, full_seen, grant_seen, stale_seen;
  bit          idle_on;

  function automatic logic [15:0] next_gen(logic [15:0] g);
    logic [15:0] n;
    n = g + 16'd1;
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  // Advance the shadow pool by one request and return the expected word
  function automatic rsp_t predict_pool(req_t r);
    rsp_t        o;
    int unsigned s;
    bit          hit;
    o = '0;
    if (r.func == FUNC_REGISTER) begin
      if (r.resource_kind == 3'd0) begin
        o.status = ST_BAD_KIND;
      end else if (free_depth == 0 && high_water >= CAP) begin
        o.status = ST_FULL;
      end else begin
        if (free_depth > 0) begin
          free_depth--;
          s = free_list[free_depth];
        end else begin
          s = high_water;
          high_water++;
        end
        pool_alive[s] = 1'b1;
        pool_kind[s]  = r.resource_kind;
        pool_pend[s]  = 1'b0;
        pool_bytes[s] = r.byte_size;
        pool_frame[s] = '0;
        live_count++;
        byte_sum += r.byte_size;
        o.status = ST_OK;
        o.out_index = 9'(s + 1);
        o.out_generation = pool_gen[s];
      end
    end else if (r.func <= FUNC_TOUCH) begin
      hit = 1'b0;
      if (r.handle_index != 0 && r.handle_index <= high_water) begin
        s = r.handle_index - 1;
        hit = pool_alive[s] && pool_gen[s] == r.handle_generation &&
              pool_kind[s] == r.resource_kind;
      end
      if (!hit) begin
        o.status = ST_BAD_HANDLE;
      end else if (r.func == FUNC_RELEASE) begin
        if (pool_pend[s]) pend_count--;
        pool_alive[s] = 1'b0;
        pool_pend[s]  = 1'b0;
        live_count--;
        byte_sum -= pool_bytes[s];
        pool_gen[s] = next_gen(pool_gen[s]);
        if (free_depth < CAP) begin
          free_list[free_depth] = s;
          free_depth++;
        end
      end else begin
        if (r.func == FUNC_MARK && !pool_pend[s]) begin
          pool_pend[s] = 1'b1;
          pend_count++;
        end else if (r.func == FUNC_TOUCH) begin
          pool_frame[s] = r.frame_index;
        end
        o.out_generation = pool_gen[s];
        o.is_pending = pool_pend[s];
        o.last_frame = pool_frame[s];
      end
    end
    o.alive_total   = 9'(live_count);
    o.free_total    = 9'(free_depth);
    o.slot_total    = 9'(high_water);
    o.pending_total = 9'(pend_count);
    o.alive_bytes   = (byte_sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : byte_sum[47:0];
    return o;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (!idle_on || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Hold the word on req_i until the pool takes it, then idle a while when a gap is picked
  task automatic send_word(req_t r);
    rsp_t o;
    int unsigned gap;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    o = predict_pool(r);
    if (o.status == ST_FULL) full_seen++;
    if (o.status == ST_BAD_HANDLE) stale_seen++;
    if (r.func == FUNC_REGISTER && o.status == ST_OK) grant_seen++;
    expected_rsp[exp_wr[1:0]] = o;
    exp_wr++;
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  function automatic req_t make_req(logic [2:0] f, logic [2:0] k, logic [8:0] idx,
                                    logic [15:0] g, logic [39:0] sz, logic [31:0] fr);
    req_t r;
    r.func = f; r.resource_kind = k; r.handle_index = idx;
    r.handle_generation = g; r.byte_size = sz; r.frame_index = fr;
    return r;
  endfunction

  function automatic logic [39:0] rand_size();
    int unsigned p;
    p = $urandom_range(9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return {8'($urandom), 32'($urandom)};
  endfunction

  // Handle request aimed at a live slot when one exists
  function automatic req_t live_req(logic [2:0] f);
    int unsigned s;
    req_t r;
    r = make_req(f, 3'($urandom_range(7, 1)), 9'($urandom), 16'($urandom),
                 rand_size(), $urandom);
    if (live_count == 0) return r;
    repeat (40) begin
      s = $urandom_range(high_water - 1);
      if (pool_alive[s]) begin
        r.handle_index = 9'(s + 1);
        r.handle_generation = pool_gen[s];
        r.resource_kind = pool_kind[s];
        return r;
      end
    end
    return r;
  endfunction

  // Compare each returned word with the oldest expectation
  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: mismatch %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && done_o) begin
      if (exp_wr == exp_rd) begin
        errors++;
        $display("%0t: unexpected word, expected none actual %h", $time, rsp_o);
      end else begin
        e = expected_rsp[exp_rd[1:0]];
        exp_rd++;
        words_checked++;
        check_field("status", e.status, rsp_o.status);
        check_field("out_index", e.out_index, rsp_o.out_index);
        check_field("out_generation", e.out_generation, rsp_o.out_generation);
        check_field("is_pending", e.is_pending, rsp_o.is_pending);
        check_field("last_frame", e.last_frame, rsp_o.last_frame);
        check_field("alive_total", e.alive_total, rsp_o.alive_total);
        check_field("free_total", e.free_total, rsp_o.free_total);
        check_field("slot_total", e.slot_total, rsp_o.slot_total);
        check_field("pending_total", e.pending_total, rsp_o.pending_total);
        check_field("alive_bytes", e.alive_bytes, rsp_o.alive_bytes);
      end
    end
  end

  // Corner cases of every request code
  task automatic test_directed();
    idle_on = 1'b0;
    send_word(make_req(FUNC_REGISTER, 3'd0, 9'd0, 16'd0, '1, '0));
    send_word(make_req(FUNC_QUERY, 3'd1, 9'd1, 16'd1, '0, '0));
    send_word(make_req(FUNC_REGISTER, 3'd1, 9'h1FF, 16'hFFFF, '0, '1));
    send_word(make_req(FUNC_REGISTER, 3'd7, 9'd0, 16'd0, '1, '0));
    send_word(make_req(FUNC_QUERY, 3'd1, 9'd0, 16'd1, '0, '0));
    send_word(make_req(FUNC_QUERY, 3'd1, 9'd256, 16'd1, '0, '0));
    send_word(make_req(FUNC_QUERY, 3'd1, 9'h1FF, 16'd1, '0, '0));
    send_word(make_req(FUNC_QUERY, 3'd1, 9'd1, 16'hFFFF, '0, '0));
    send_word(make_req(FUNC_QUERY, 3'd2, 9'd1, 16'd1, '0, '0));
    send_word(make_req(FUNC_QUERY, 3'd0, 9'd1, 16'd1, '0, '0));
    send_word(make_req(FUNC_MARK, 3'd1, 9'd1, 16'd1, '0, '0));
    send_word(make_req(FUNC_MARK, 3'd1, 9'd1, 16'd1, '0, '0));
    send_word(make_req(FUNC_TOUCH, 3'd7, 9'd2, 16'd1, '0, '1));
    send_word(make_req(FUNC_QUERY, 3'd7, 9'd2, 16'd1, '1, '0));
    send_word(make_req(FUNC_RELEASE, 3'd1, 9'd1, 16'd1, '0, '0));
    send_word(make_req(FUNC_RELEASE, 3'd1, 9'd1, 16'd1, '0, '0));
    send_word(make_req(FUNC_REGISTER, 3'd3, 9'd0, 16'd0, 40'h12_3456_789A, '0));
    send_word(make_req(FUNC_QUERY, 3'd3, 9'd1, 16'd2, '0, '0));
    send_word(make_req(FUNC_TOUCH, 3'd7, 9'd2, 16'd1, '0, '0));
    send_word(make_req(3'd5, 3'd1, 9'd1, 16'd2, '1, '1));
    send_word(make_req(3'd6, 3'd7, 9'h1FF, 16'hFFFF, '1, '1));
    send_word(make_req(3'd7, 3'd0, 9'd0, 16'd0, '0, '0));
  endtask

  // Fill the pool to capacity, hit pool full, then drain part of it
  task automatic test_exhaust();
    idle_on = 1'b1;
    while (high_water < CAP || free_depth > 0)
      send_word(make_req(FUNC_REGISTER, 3'($urandom_range(7, 1)), 9'($urandom),
                         16'($urandom), rand_size(), $urandom));
    send_word(make_req(FUNC_REGISTER, 3'd5, 9'd0, 16'd0, '1, '0));
    send_word(make_req(FUNC_REGISTER, 3'd0, 9'd0, 16'd0, '1, '0));
    repeat (200) send_word(live_req(FUNC_RELEASE));
  endtask

  // Mostly valid handle traffic with random content and some noise
  task automatic test_random(int unsigned count);
    int unsigned p;
    req_t r;
    repeat (count) begin
      if ($urandom_range(99) < 10) idle_on = ~idle_on;
      p = $urandom_range(99);
      if (p < 30)
        r = make_req(FUNC_REGISTER, 3'($urandom_range(7, 1)), 9'($urandom),
                     16'($urandom), rand_size(), $urandom);
      else if (p < 45) r = live_req(FUNC_RELEASE);
      else if (p < 55) r = live_req(FUNC_MARK);
      else if (p < 65) r = live_req(FUNC_QUERY);
      else if (p < 78) r = live_req(FUNC_TOUCH);
      else if (p < 88) begin
        r = live_req(3'($urandom_range(4, 1)));
        if ($urandom_range(1)) r.handle_generation ^= 16'(1 << $urandom_range(15));
        else r.resource_kind = 3'($urandom);
      end else begin
        r = make_req(3'($urandom), 3'($urandom), 9'($urandom), 16'($urandom),
                     {8'($urandom), 32'($urandom)}, $urandom);
      end
      send_word(r);
    end
  endtask

  initial begin
    for (int i = 0; i < CAP; i++) begin
      pool_alive[i] = 1'b0;
      pool_gen[i] = 16'd1;
    end
    free_depth = 0; high_water = 0; live_count = 0; pend_count = 0; byte_sum = 0;
    errors = 0; words_sent = 0; words_checked = 0;
    full_seen = 0; grant_seen = 0; stale_seen = 0;
    exp_wr = 0; exp_rd = 0;
    idle_on = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_exhaust();
    test_random(650);

    @(negedge clk_i);
    start <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (exp_wr != exp_rd) errors++;

    $display("Sent %0d requests, checked %0d results: %0d grants, %0d pool full, %0d rejected",
             words_sent, words_checked, grant_seen, full_seen, stale_seen);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Run time limit
  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

endmodule
